// ===== hw/rtl/wavetable_oscillator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Wavetable oscillator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_UNIT_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WTO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WTO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wtosc_pkg.sv =====
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Field widths, register codes, operation codes and controller states.
// ----------------------------------------------------------------------------
package wtosc_pkg;

  // Fixed field widths.
  localparam int PHASE_W      = 34;
  localparam int SR_W         = 18;
  localparam int LEN_W        = 11;
  localparam int SAMPLE_W     = 16;
  localparam int ENTRY_IDX_W  = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 34;
  localparam int FRAC_W       = 16;

  // Default table depth.
  localparam int TABLE_DEPTH_DEF = 1024;

  // Register values after reset.
  localparam logic [SR_W-1:0]    SR_RESET   = 18'd44100;
  localparam logic [PHASE_W-1:0] FREQ_RESET = 34'd28835840;
  localparam logic [LEN_W-1:0]   LEN_RESET  = 11'd1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE  = 2'd0,
    CFG_FREQUENCY    = 2'd1,
    CFG_TABLE_LENGTH = 2'd2
  } cfg_reg_e;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PHASE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_READ,
    ST_RDATA,
    ST_WCHK
  } state_e;

  // Result hand-off state, kept apart so the enum stays within three bits.
  typedef struct packed {
    logic pending;
    logic is_tick;
  } result_t;

endpackage

// ===== hw/rtl/wtosc_store.sv =====
// ----------------------------------------------------------------------------
// Wavetable sample store
// Single-port-write, registered-read sample memory with a clearing sweep
// after reset.
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_unit_assert.svh"

module wtosc_store #(
  parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [ADDR_W-1:0]             rd_addr_i,
  output logic [wtosc_pkg::SAMPLE_W-1:0] rd_data_o,
  input  logic                          wr_en_i,
  input  logic [ADDR_W-1:0]             wr_addr_i,
  input  logic [wtosc_pkg::SAMPLE_W-1:0] wr_data_i,
  output logic                          clr_done_o
);
  import wtosc_pkg::*;

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                clr_busy_q;
  logic [ADDR_W-1:0]   clr_addr_q;

  // The clearing sweep walks every entry once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Memory write port; the sweep owns it until it finishes.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_done_o = !clr_busy_q;

  `WTO_ASSERT_NOW(a_no_write_in_clear, clr_busy_q, !wr_en_i, "write during clearing sweep")

endmodule

// ===== hw/rtl/wtosc_div.sv =====
// ----------------------------------------------------------------------------
// Wavetable index divider
// Restoring divider producing one quotient bit per cycle. The caller
// guarantees the quotient fits in QUOT_W bits.
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_unit_assert.svh"

module wtosc_div #(
  parameter int QUOT_W = 10,
  parameter int DVD_W  = 29
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DVD_W-1:0]           dividend_i,
  input  logic [wtosc_pkg::SR_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [QUOT_W-1:0]          quotient_o
);
  import wtosc_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SR_W-1:0]   rem_q;
  logic [QUOT_W-1:0] qsh_q;
  logic [SR_W:0]     trial;
  logic              ge;

  // One trial subtraction per step.
  always_comb begin
    trial = {rem_q, qsh_q[QUOT_W-1]};
    ge    = (trial >= {1'b0, divisor_i});
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the upper dividend bits seed the remainder, the lower bits
  // shift through and are replaced by quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= SR_W'(dividend_i >> QUOT_W);
      qsh_q <= dividend_i[QUOT_W-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? SR_W'(trial - {1'b0, divisor_i}) : trial[SR_W-1:0];
      qsh_q <= QUOT_W'({qsh_q, ge});
    end
  end

  assign done_o     = done_q;
  assign quotient_o = qsh_q;

  `WTO_ASSERT_NOW(a_start_when_free, start_i, !busy_q, "divider started while busy")

endmodule

// ===== hw/rtl/wavetable_oscillator_unit.sv =====
// ----------------------------------------------------------------------------
// Wavetable oscillator unit
// Sequencing: a tick passes the multiply state, the bit-serial divider if a division is
//   needed, and the table read; an in-range write reads the old entry, then writes; other
//   words finish directly. The next word is taken once the result has left res_q.
// Reset: configuration and control registers return to defaults, then a sweep clears
//   every entry of the sample store, during which no word is accepted.
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_unit_assert.svh"

module wavetable_oscillator_unit #(
  parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [wtosc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wtosc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic [wtosc_pkg::ENTRY_IDX_W-1:0]   entry_index_i,
  input  logic signed [wtosc_pkg::SAMPLE_W-1:0] entry_value_i,
  input  logic [wtosc_pkg::PHASE_W-1:0]       phase_value_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wtosc_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [wtosc_pkg::PHASE_W-1:0]       phase_out_o,
  output logic                                has_content_o
);
  import wtosc_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int LW     = $clog2(TABLE_DEPTH + 1);
  localparam int PW     = PHASE_W + LW;
  localparam int DW     = PW - FRAC_W;
  localparam int CW     = $clog2(TABLE_DEPTH + 1);

  // Configuration registers.
  logic [SR_W-1:0]    cfg_sr_q;
  logic [PHASE_W-1:0] cfg_freq_q;
  logic [LEN_W-1:0]   cfg_len_q;

  // Controller and datapath registers.
  state_e                     state_q, state_d;
  result_t                    res_q, res_d;
  op_e                        op_in;
  logic [ADDR_W-1:0]          widx_q;
  logic [SAMPLE_W-1:0]        wval_q;
  logic [PHASE_W-1:0]         phase_q;
  logic [LW-1:0]              len_q;
  logic [PW-1:0]              prod_q;
  logic [ADDR_W-1:0]          idx_q;
  logic [SAMPLE_W-1:0]        sample_q;
  logic [CW-1:0]              count_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic [PHASE_W-1:0]         out_phase_q;
  logic                       out_has_q;

  // Combinational helpers.
  logic                 in_accept;
  logic                 idx_in_range;
  logic                 out_free;
  logic                 res_load;
  logic [PHASE_W-1:0]   rate;
  logic                 rate_zero;
  logic [PHASE_W-1:0]   step;
  logic [PHASE_W:0]     sum;
  logic [PHASE_W:0]     wrapped;
  logic [LW-1:0]        len_used;

  // Store and divider connections.
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0]  rd_data;
  logic                 wr_en;
  logic                 clr_done;
  logic                 div_start;
  logic                 div_done;
  logic [ADDR_W-1:0]    div_quot;

  assign op_in        = op_e'(operation_i);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign idx_in_range = (32'(entry_index_i) < TABLE_DEPTH);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign res_load     = res_q.pending && out_free;

  // Rate, clamped step and phase advance with a single wrap.
  always_comb begin
    rate      = {cfg_sr_q, {FRAC_W{1'b0}}};
    rate_zero = (cfg_sr_q == '0);
    step      = (cfg_freq_q > rate) ? rate : cfg_freq_q;
    sum       = {1'b0, phase_q} + {1'b0, step};
    wrapped   = (sum >= {1'b0, rate}) ? sum - {1'b0, rate} : sum;
  end

  // Table length in use, limited to one and the table depth.
  always_comb begin
    if (cfg_len_q == '0) begin
      len_used = LW'(1);
    end else if (32'(cfg_len_q) > TABLE_DEPTH) begin
      len_used = LW'(TABLE_DEPTH);
    end else begin
      len_used = LW'(cfg_len_q);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sr_q   <= SR_RESET;
      cfg_freq_q <= FREQ_RESET;
      cfg_len_q  <= LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_SAMPLE_RATE:  cfg_sr_q   <= cfg_wdata_i[SR_W-1:0];
        CFG_FREQUENCY:    cfg_freq_q <= cfg_wdata_i[PHASE_W-1:0];
        CFG_TABLE_LENGTH: cfg_len_q  <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // Next state and memory port control. A finished item waits in res_q
  // until the output register can take it; no new word enters meanwhile.
  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    rd_en     = 1'b0;
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    div_start = 1'b0;
    if (res_load) begin
      res_d.pending = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = ADDR_W'(entry_index_i);
        if (in_accept) begin
          res_d.is_tick = (op_in == OP_TICK);
          unique case (op_in)
            OP_TICK: state_d = ST_MUL;
            OP_WRITE: begin
              if (idx_in_range) begin
                rd_en   = 1'b1;
                state_d = ST_WCHK;
              end else begin
                res_d.pending = 1'b1;
              end
            end
            default: res_d.pending = 1'b1;
          endcase
        end
      end
      ST_MUL: begin
        if (rate_zero || (phase_q >= rate)) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DSTART;
        end
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        res_d.pending = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_WCHK: begin
        wr_en         = 1'b1;
        res_d.pending = 1'b1;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Input stalls outside idle and while a finished result is held back.
  assign in_stall_o = (state_q != ST_IDLE) || res_q.pending;

  // Item datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          widx_q   <= ADDR_W'(entry_index_i);
          wval_q   <= entry_value_i;
          len_q    <= len_used;
          sample_q <= '0;
        end
      end
      ST_MUL: begin
        prod_q <= PW'(phase_q) * PW'(len_q);
        if (rate_zero) begin
          idx_q <= '0;
        end else begin
          idx_q <= ADDR_W'(len_q - 1'b1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          idx_q <= div_quot;
        end
      end
      ST_RDATA: begin
        sample_q <= rd_data;
      end
      default: ;
    endcase
  end

  // Phase accumulator and nonzero entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      count_q <= '0;
    end else begin
      if (state_q == ST_IDLE && in_accept && op_in == OP_PHASE) begin
        phase_q <= phase_value_i;
      end else if (state_q == ST_MUL && rate_zero) begin
        phase_q <= '0;
      end else if (state_q == ST_READ) begin
        phase_q <= wrapped[PHASE_W-1:0];
      end
      if (state_q == ST_WCHK) begin
        if (rd_data != '0 && wval_q == '0) begin
          count_q <= count_q - 1'b1;
        end else if (rd_data == '0 && wval_q != '0) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_sample_q <= res_q.is_tick ? sample_q : '0;
      out_phase_q  <= phase_q;
      out_has_q    <= (count_q != '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_sample_q;
  assign phase_out_o   = out_phase_q;
  assign has_content_o = out_has_q;

  wtosc_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (widx_q),
    .wr_data_i  (wval_q),
    .clr_done_o (clr_done)
  );

  wtosc_div #(
    .QUOT_W (ADDR_W),
    .DVD_W  (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[PW-1:FRAC_W]),
    .divisor_i  (cfg_sr_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  `WTO_ASSERT_NOW(a_quot_in_range, div_done, LW'(div_quot) < len_q, "index beyond table length")
  `WTO_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH), "nonzero count overflow")
  `WTO_ASSERT_NEXT(a_result_held, res_q.pending && !out_free, res_q.pending, "result dropped")

endmodule
